[hdl/fractional_delay_line_core_macros.svh]
// Assertion macros for the delay line core
`ifndef FRACTIONAL_DELAY_LINE_CORE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define FDL_ASSERT_NOW(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define FDL_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define FDL_ASSERT_NOW(lbl, clk, rst, cond, prop)
`define FDL_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif

`endif

[hdl/fdl_pkg.sv]
`default_nettype none

package fdl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int DELAY_W   = 20;
  localparam int RATE_W    = 18;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = DELAY_W + RATE_W;
  localparam int WHOLE_W   = PROD_W - FRAC_W;

  // divide by 1000 in two reciprocal steps: the top HI_W product bits first, then
  // their remainder joined to the low SPLIT_W bits, which stays below 2^29
  localparam int SPLIT_W   = 19;
  localparam int HI_W      = PROD_W - SPLIT_W;
  localparam int QH_W      = 10;
  localparam int RECIP_W   = 29;
  localparam int RECIP_SH  = 38;

  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;  // ceil(2^38 / 1000)
  localparam logic [HI_W-1:0]    MS_PER_S   = 19'd1000;
  localparam logic [RATE_W-1:0]  RATE_RESET = 18'd48000;

  // shared multiplier operand widths
  localparam int MUL_X_W = 30;
  localparam int MUL_Y_W = 30;
  localparam int MUL_P_W = MUL_X_W + MUL_Y_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DH,
    S_DR,
    S_DL,
    S_SAT,
    S_RDA,
    S_RDB,
    S_GETB,
    S_MULI,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[hdl/fdl_ram.sv]
`default_nettype none

module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/fractional_delay_line_core.sv]
// Sequence: after an input transfer the sequencer steps through the product, two reciprocal
//   steps and a remainder for the divide by 1000, clamp, two store reads, interpolation.
// Input ready only while the sequencer is idle, so one item is finished before the next is taken;
//   a result still held in the output register stalls the sequencer before the store write.
// Reset (rst, synchronous): sequencer idle, write index and fill count zero, rate 48000;
//   store entries not written since reset read as zero through the fill count.
`default_nettype none

`include "fractional_delay_line_core_macros.svh"

module fractional_delay_line_core
  import fdl_pkg::*;
#(
  parameter int DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [17:0] cfg_wr_data,   // sample_rate
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [23:0] sample_in, [43:24] delay_ms, [47:44] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [23:0] sample_out
  output logic             m_axis_tuser   // [0] delay_clipped
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0]      LIMIT_IDX   = AW'(DEPTH - 3);
  localparam logic [WHOLE_W-1:0] LIMIT_WHOLE = WHOLE_W'(DEPTH - 3);
  localparam logic [AW:0]        FULL        = (AW + 1)'(DEPTH);

  state_t state, state_next;

  logic [RATE_W-1:0]   sample_rate;
  logic [SAMPLE_W-1:0] sample;
  logic [DELAY_W-1:0]  dms;
  logic [PROD_W-1:0]   quot;
  logic [QH_W-1:0]     qh;
  logic [QH_W-1:0]     rh;
  logic [FRAC_W-1:0]   frac;
  logic                clip;
  logic [AW-1:0]       ra;
  logic [AW-1:0]       rb;
  logic                valid_a;
  logic                valid_b;
  logic [SAMPLE_W-1:0] a;
  logic [SAMPLE_W-1:0] b;
  logic [31:FRAC_W]    ip;
  logic [AW-1:0]       wi;
  logic [AW:0]         fill;
  logic [SAMPLE_W-1:0] out_data;
  logic                out_valid;
  logic                out_clip;

  logic                ram_we;
  logic [AW-1:0]       ram_rd_addr;
  logic [SAMPLE_W-1:0] ram_rd_data;
  logic                in_xfer;
  logic                out_free;

  // delay clamp and read addresses
  logic [WHOLE_W-1:0] q_whole;
  logic               clip_w;
  logic [AW-1:0]      whole_c;
  logic [AW-1:0]      ka;
  logic [AW-1:0]      kb;
  logic [AW-1:0]      ra_w;

  // shared multiplier
  logic signed [MUL_X_W-1:0] mul_x;
  logic signed [MUL_Y_W-1:0] mul_y;
  logic signed [MUL_P_W-1:0] mul_p;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  assign q_whole = quot[PROD_W-1:FRAC_W];
  assign clip_w  = q_whole > LIMIT_WHOLE;
  assign whole_c = clip_w ? LIMIT_IDX : q_whole[AW-1:0];
  assign ka      = whole_c + AW'(1);
  assign kb      = whole_c + AW'(2);
  assign ra_w    = wi - ka;

  always_comb begin
    case (state)
      S_MUL: begin
        mul_x = $signed({{(MUL_X_W - DELAY_W){1'b0}}, dms});
        mul_y = $signed({{(MUL_Y_W - RATE_W){1'b0}}, sample_rate});
      end
      S_DH: begin
        mul_x = $signed({{(MUL_X_W - HI_W){1'b0}}, quot[PROD_W-1:SPLIT_W]});
        mul_y = $signed({{(MUL_Y_W - RECIP_W){1'b0}}, RECIP_1000});
      end
      S_DL: begin
        mul_x = $signed({{(MUL_X_W - QH_W - SPLIT_W){1'b0}}, rh, quot[SPLIT_W-1:0]});
        mul_y = $signed({{(MUL_Y_W - RECIP_W){1'b0}}, RECIP_1000});
      end
      default: begin
        mul_x = $signed({{(MUL_X_W - SAMPLE_W){b[SAMPLE_W-1]}}, b})
              - $signed({{(MUL_X_W - SAMPLE_W){a[SAMPLE_W-1]}}, a});
        mul_y = $signed({{(MUL_Y_W - FRAC_W){1'b0}}, frac});
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_rd_addr   = rb;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_DH;
      S_DH:  state_next = S_DR;
      S_DR:  state_next = S_DL;
      S_DL:  state_next = S_SAT;
      S_SAT: state_next = S_RDA;
      S_RDA: begin
        ram_rd_addr = ra;
        state_next  = S_RDB;
      end
      S_RDB:  state_next = S_GETB;
      S_GETB: state_next = S_MULI;
      S_MULI: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RATE_RESET;
      wi          <= '0;
      fill        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sample_rate <= cfg_wr_data;
      end
      if (ram_we) begin
        wi        <= wi + AW'(1);
        out_valid <= 1'b1;
        if (fill != FULL) begin
          fill <= fill + (AW + 1)'(1);
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample <= s_axis_tdata[SAMPLE_W-1:0];
      dms    <= s_axis_tdata[SAMPLE_W +: DELAY_W];
    end
    case (state)
      S_MUL: quot <= mul_p[PROD_W-1:0];
      // quotient of the top bits, then their remainder
      S_DH:  qh   <= mul_p[RECIP_SH +: QH_W];
      S_DR:  rh   <= QH_W'(quot[PROD_W-1:SPLIT_W] - HI_W'(qh) * MS_PER_S);
      S_DL:  quot <= {{(PROD_W - QH_W - SPLIT_W){1'b0}}, qh, mul_p[RECIP_SH +: SPLIT_W]};
      S_SAT: begin
        clip    <= clip_w;
        frac    <= clip_w ? '0 : quot[FRAC_W-1:0];
        ra      <= ra_w;
        rb      <= ra_w - AW'(1);
        // entry k places behind the write index holds data once k < fill
        valid_a <= {1'b0, ka} < fill;
        valid_b <= {1'b0, kb} < fill;
      end
      S_RDB:  a  <= valid_a ? ram_rd_data : '0;
      S_GETB: b  <= valid_b ? ram_rd_data : '0;
      S_MULI: ip <= mul_p[31:FRAC_W];
      S_DONE: begin
        if (out_free) begin
          // floor((256a + t(b-a))/256) = a + floor(t(b-a)/256)
          out_data <= a + ip[31:FRAC_W];
          out_clip <= clip;
        end
      end
      default: ;
    endcase
  end

  fdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wi + AW'(1)),
    .wr_data (sample),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_clip;

  `FDL_ASSERT_NOW(a_we_has_room, clk, rst, ram_we, !out_valid || m_axis_tready)
  `FDL_ASSERT_NEXT(a_we_gives_result, clk, rst, ram_we, m_axis_tvalid && state == S_IDLE)
  `FDL_ASSERT_NEXT(a_accept_starts, clk, rst, in_xfer, state == S_MUL && !s_axis_tready)
  `FDL_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FULL)

endmodule

`default_nettype wire
